>>> hdl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions, disabled while reset is held.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the rising edge of aclk.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication on the rising edge of aclk.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

>>> hdl/ppst_pkg.sv
// -----------------------------------------------------------------------------
// ppst_pkg
// Shared types and constants of the peer presence and sync tracker.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppst_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_GROUP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEER_TIMEOUT = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

    // Item kinds carried in s_tuser.
    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    localparam int S_DATA_W = 224;
    localparam int M_DATA_W = 48;
    localparam int NAME_W   = 128;
    localparam int TC_W     = 40;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_idx;
        logic rd_slot;
        logic inc_idx;
        logic touch;
        logic clear_stale;
        logic append;
        logic finish;
    } ppst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic pkt_ok;
        logic fill_zero;
        logic last_slot;
        logic match;
        logic out_free;
    } ppst_sts_t;

endpackage

>>> hdl/ppst_ram.sv
// -----------------------------------------------------------------------------
// ppst_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ppst_ctrl.sv
// -----------------------------------------------------------------------------
// ppst_ctrl
// Sequencer: takes an item, scans filled peer slots as needed, then closes it.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppst_ctrl
    import ppst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ppst_sts_t sts,
    output ppst_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_CMP,
        ST_APPEND,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (ready_reg && s_tvalid) begin
                    cmd.load   = 1'b1;
                    ready_next = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                cmd.clr_idx = 1'b1;
                if (sts.is_tick) begin
                    state_next = sts.fill_zero ? ST_FINISH : ST_READ;
                end else if (!sts.pkt_ok) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = sts.fill_zero ? ST_APPEND : ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_slot = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                if (sts.is_tick) begin
                    cmd.clear_stale = 1'b1;
                    cmd.inc_idx     = 1'b1;
                    state_next      = sts.last_slot ? ST_FINISH : ST_READ;
                end else if (sts.match) begin
                    cmd.touch  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.inc_idx = 1'b1;
                    state_next  = sts.last_slot ? ST_APPEND : ST_READ;
                end
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold until the result register can take the new result.
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

>>> hdl/ppst_dp.sv
// -----------------------------------------------------------------------------
// ppst_dp
// Datapath: item and configuration registers, peer table, sync state, result.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppst_dp
    import ppst_pkg::*;
#(
    parameter int PEER_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ppst_cmd_t             cmd,
    output ppst_sts_t             sts,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam int AW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int FW = $clog2(PEER_SLOTS + 1);

    // Keep name bytes up to and including the first zero byte, clear the rest.
    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic              alive;
        logic [NAME_W-1:0] res;
        alive = 1'b1;
        res   = '0;
        for (int b = 0; b < NAME_W / 8; b++) begin
            if (alive) begin
                res[b*8 +: 8] = raw[b*8 +: 8];
            end
            if (raw[b*8 +: 8] == 8'd0) begin
                alive = 1'b0;
            end
        end
        return res;
    endfunction

    // Configuration.
    logic [7:0]  own_group_reg;
    logic [7:0]  own_id_reg;
    logic        master_mode_reg;
    logic [15:0] timeout_reg;

    // Latched item.
    logic              kind_reg;
    logic [31:0]       now_reg;
    logic [7:0]        group_reg;
    logic [7:0]        sender_reg;
    logic [NAME_W-1:0] name_reg;
    logic              smaster_reg;
    logic [TC_W-1:0]   tc_reg;

    // Peer table control and sync state.
    logic [FW-1:0]         idx_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         count_reg;
    logic [PEER_SLOTS-1:0] active_reg;
    logic                  sync_flag_reg;
    logic [31:0]           sync_time_reg;

    // Result register.
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [NAME_W-1:0] name_rd;
    logic [31:0]       seen_rd;
    logic              full;
    logic              do_append;
    logic              do_clear;
    logic              pkt_ok;
    logic              gain;
    logic              lose;
    logic              sync_flag_next;
    logic [AW-1:0]     idx_a;
    logic [AW-1:0]     fill_a;
    logic [AW-1:0]     seen_waddr;
    logic [TC_W-1:0]   tc_out;

    assign idx_a  = idx_reg[AW-1:0];
    assign fill_a = fill_reg[AW-1:0];
    assign full   = (fill_reg == FW'(PEER_SLOTS));
    assign pkt_ok = (group_reg == own_group_reg) && (sender_reg != own_id_reg);

    assign do_append  = cmd.append && !full;
    assign do_clear   = cmd.clear_stale && ((now_reg - seen_rd) > {16'd0, timeout_reg});
    assign seen_waddr = cmd.append ? fill_a : idx_a;

    ppst_ram #(
        .WIDTH (NAME_W),
        .DEPTH (PEER_SLOTS)
    ) u_name_ram (
        .aclk  (aclk),
        .we    (do_append),
        .waddr (fill_a),
        .wdata (name_reg),
        .re    (cmd.rd_slot),
        .raddr (idx_a),
        .rdata (name_rd)
    );

    ppst_ram #(
        .WIDTH (32),
        .DEPTH (PEER_SLOTS)
    ) u_seen_ram (
        .aclk  (aclk),
        .we    (do_append || cmd.touch),
        .waddr (seen_waddr),
        .wdata (now_reg),
        .re    (cmd.rd_slot),
        .raddr (idx_a),
        .rdata (seen_rd)
    );

    // A stored name with an empty first byte never matches.
    assign sts.is_tick   = (kind_reg == KIND_TICK);
    assign sts.pkt_ok    = pkt_ok;
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.last_slot = ({1'b0, idx_reg} + (FW + 1)'(1)) == {1'b0, fill_reg};
    assign sts.match     = (name_rd[7:0] != 8'd0) && (name_rd == name_reg);
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign gain = (kind_reg == KIND_PACKET) && pkt_ok && !master_mode_reg && smaster_reg;
    assign lose = (kind_reg == KIND_TICK) && sync_flag_reg && !master_mode_reg &&
                  ((now_reg - sync_time_reg) > {15'd0, timeout_reg, 1'b0});

    always_comb begin
        sync_flag_next = sync_flag_reg;
        if (gain) begin
            sync_flag_next = 1'b1;
        end else if (lose) begin
            sync_flag_next = 1'b0;
        end
    end

    assign tc_out = gain ? tc_reg : '0;

    // Configuration and item registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_group_reg   <= 8'd0;
            own_id_reg      <= 8'd0;
            master_mode_reg <= 1'b0;
            timeout_reg     <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_OWN_GROUP:    own_group_reg   <= cfg_wdata[7:0];
                REG_OWN_ID:       own_id_reg      <= cfg_wdata[7:0];
                REG_MASTER_MODE:  master_mode_reg <= cfg_wdata[0];
                REG_PEER_TIMEOUT: timeout_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= s_tuser;
            now_reg     <= s_tdata[31:0];
            group_reg   <= s_tdata[39:32];
            sender_reg  <= s_tdata[47:40];
            name_reg    <= trim_name(s_tdata[175:48]);
            smaster_reg <= s_tdata[176];
            tc_reg      <= s_tdata[216:177];
        end
    end

    // Peer table bookkeeping and sync state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= '0;
            sync_flag_reg <= 1'b0;
            sync_time_reg <= 32'd0;
        end else begin
            if (cmd.clr_idx) begin
                idx_reg <= '0;
            end else if (cmd.inc_idx) begin
                idx_reg <= idx_reg + FW'(1);
            end
            if (cmd.touch) begin
                active_reg[idx_a] <= 1'b1;
                if (!active_reg[idx_a]) begin
                    count_reg <= count_reg + FW'(1);
                end
            end else if (do_clear) begin
                active_reg[idx_a] <= 1'b0;
                if (active_reg[idx_a]) begin
                    count_reg <= count_reg - FW'(1);
                end
            end else if (do_append) begin
                // Slots at or beyond the fill level are never active.
                active_reg[fill_a] <= 1'b1;
                count_reg          <= count_reg + FW'(1);
                fill_reg           <= fill_reg + FW'(1);
            end
            if (cmd.finish) begin
                sync_flag_reg <= sync_flag_next;
                if (gain) begin
                    sync_time_reg <= now_reg;
                end
            end
        end
    end

    // Result register; a finished result waits here until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= {1'b0, 4'(count_reg), lose,
                           sync_flag_next | master_mode_reg, tc_out, gain};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hdl/peer_presence_sync_tracker.sv
// Flow: an accepted item passes a dispatch step, then a read and a compare step
// per peer slot scanned (all filled slots for a tick, none for a rejected packet,
// up to the match otherwise), then an append step when an unmatched name reaches it,
// and the finish step, which holds while the result register is still occupied.
// The next item waits for the last result to register; scan and hold set the rate.
// Reset: synchronous, active low; clears fill level, active bits and sync state.
// -----------------------------------------------------------------------------
// peer_presence_sync_tracker
// Tracks sync-link peers by name and forwards master timecode to the follower.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peer_presence_sync_tracker
    import ppst_pkg::*;
#(
    parameter int PEER_SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], pkt_group[39:32], sender_id[47:40], name_low[111:48],
    // name_high[175:112], sender_master[176], tc_hours[184:177],
    // tc_minutes[192:185], tc_seconds[200:193], tc_frames[208:201],
    // rate_index[216:209], zero fill above.
    input  logic [S_DATA_W-1:0]   s_tdata,
    // kind: 0 received packet, 1 periodic tick.
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // timecode_valid[0], out_hours[8:1], out_minutes[16:9], out_seconds[24:17],
    // out_frames[32:25], out_rate_index[40:33], is_synced[41], sync_lost[42],
    // active_peers[46:43], zero fill above.
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ppst_cmd_t cmd;
    ppst_sts_t sts;

    ppst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ppst_dp #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hdl/ppst_checker.sv
// -----------------------------------------------------------------------------
// ppst_checker
// Port-level checks on the result channel of the tracker.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppst_port_checks
    import ppst_pkg::*;
#(
    parameter int PEER_SLOTS = 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result transaction keeps its payload.
    `ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

    // Timecode bytes are zero unless a master timecode was taken.
    `ASSERT_SAME(a_tc_zero, m_tvalid && !m_tdata[0], m_tdata[40:1] == 40'd0)

    // Taking a master timecode leaves the node synced.
    `ASSERT_SAME(a_tc_synced, m_tvalid && m_tdata[0], m_tdata[41])

    // Losing sync on a tick means the node is no longer synced.
    `ASSERT_SAME(a_lost_unsynced, m_tvalid && m_tdata[42], !m_tdata[41])

    // The active count never exceeds the table size (checked up to 15 slots).
    `ASSERT_SAME(a_count_range, m_tvalid, (PEER_SLOTS > 15) || (32'(m_tdata[46:43]) <= PEER_SLOTS))

endmodule

bind peer_presence_sync_tracker ppst_port_checks #(
    .PEER_SLOTS (PEER_SLOTS)
) u_ppst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
